// File: src/tlue_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlue_pkg: shared constants for the unique edge extractor
// Field widths, register indexes, opcodes and result kinds.
// ----------------------------------------------------------------------------
package tlue_pkg;

	// Fixed field widths of the stream and register interfaces.
	localparam int VERTEX_W    = 32;
	localparam int COUNT_W     = 13;
	localparam int CAP_W       = 12;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_DATA_W  = 12;

	// Default sizing of the block.
	localparam int MAX_TRIANGLES_DEF = 1024;
	localparam int INDEX_BITS_DEF    = 32;
	localparam int DIGIT_BITS_DEF    = 11;

	// Reset values and limits.
	localparam logic [CAP_W-1:0]   CAP_RESET = 12'd3072;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

	// Register indexes of the configuration port.
	localparam logic REG_COUNT_ONLY = 1'b0;
	localparam logic REG_CAPACITY   = 1'b1;

	// Input opcodes and result kinds.
	localparam logic OP_ADD       = 1'b0;
	localparam logic OP_FETCH     = 1'b1;
	localparam logic KIND_EDGE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

endpackage : tlue_pkg
`default_nettype wire

// File: src/tlue_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlue_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlue_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : tlue_ram
`default_nettype wire

// File: src/triangle_list_to_unique_edges.sv
// Flow: a triangle beat that fits writes its first key as it is taken and the other
// two in S_LOAD through the single key write port; no beat is taken meanwhile.
// After the last triangle, each radix pass clears the histogram, counts digits, forms the
// prefix sum and scatters the keys; keys found already in order skip to dedup. A fetch
// beat reads the key memory in S_FETCH_RD and its edge is registered in S_FETCH_OUT.
// Reset (arst_n low) clears all control state; key memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_list_to_unique_edges: triangle list to sorted unique edge list
// Stores edge keys, radix sorts them through a digit histogram memory,
// removes duplicates and streams the edges back on request.
// ----------------------------------------------------------------------------
module triangle_list_to_unique_edges #(
	parameter int MAX_TRIANGLES = tlue_pkg::MAX_TRIANGLES_DEF,
	parameter int INDEX_BITS    = tlue_pkg::INDEX_BITS_DEF,
	parameter int DIGIT_BITS    = tlue_pkg::DIGIT_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Configuration write port.
	input  wire                                cfg_we,
	input  wire                                cfg_index,
	input  wire [tlue_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input stream.
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: first_vertex[31:0], second_vertex[63:32], third_vertex[95:64]
	input  wire [tlue_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser: opcode
	input  wire                                s_axis_tuser,
	input  wire                                s_axis_tlast,
	// Result stream.
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// tdata: valid_res[0], vertex_high[32:1], vertex_low[64:33],
	//        index_count[77:65], zero[79:78]
	output logic [tlue_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// tuser: kind
	output logic                               m_axis_tuser,
	output logic                               m_axis_tlast
);

	localparam int KEY_SLOTS = 3 * MAX_TRIANGLES;
	localparam int KW        = 2 * INDEX_BITS;
	localparam int ADDR_W    = $clog2(KEY_SLOTS);
	localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
	localparam int PASSES    = (KW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PASS_W    = $clog2(PASSES + 1);
	localparam int SH_W      = $clog2(KW);
	localparam int HIST_D    = 1 << DIGIT_BITS;
	localparam int PAIR_W    = (CNT_W > tlue_pkg::CAP_W ? CNT_W : tlue_pkg::CAP_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_START, S_CLR, S_CNT_RD, S_CNT_HR, S_CNT_WR,
		S_PFX_RD, S_PFX_WR, S_SCT_RD, S_SCT_HR, S_SCT_WR,
		S_DD_RD0, S_DD_FIRST, S_DD_RD, S_DD_CMP, S_SUM, S_FETCH_RD, S_FETCH_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic                       count_only_q;
	logic [tlue_pkg::CAP_W-1:0] cap_q;

	// List bookkeeping.
	logic              list_done_q;
	logic [CNT_W-1:0]  edge_total_q;
	logic [CNT_W-1:0]  unique_q;
	logic [CNT_W-1:0]  fetch_ptr_q;
	logic              last_q;
	logic [1:0]        step_q;
	logic [INDEX_BITS-1:0] va_q, vb_q, vc_q;

	// Sort working registers.
	logic                  src_sel_q;
	logic [PASS_W-1:0]     pass_q;
	logic [SH_W-1:0]       shift_q;
	logic [DIGIT_BITS-1:0] hidx_q;
	logic [CNT_W-1:0]      kidx_q;
	logic [CNT_W-1:0]      run_q;
	logic [CNT_W-1:0]      kept_q;
	logic [DIGIT_BITS-1:0] digit_q;
	logic [KW-1:0]         key_q;
	logic [KW-1:0]         prev_q;
	logic                  in_order_q;

	// Output register.
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic                         out_vres_q;
	logic [tlue_pkg::VERTEX_W-1:0] out_hi_q;
	logic [tlue_pkg::VERTEX_W-1:0] out_lo_q;
	logic                         out_final_q;
	logic [tlue_pkg::COUNT_W-1:0] out_count_q;

	// Memory ports.
	logic              ka_we, kb_we, h_we;
	logic [ADDR_W-1:0] ka_waddr, kb_waddr, ka_raddr, kb_raddr;
	logic [KW-1:0]     ka_wdata, kb_wdata, ka_rdata, kb_rdata;
	logic [DIGIT_BITS-1:0] h_waddr, h_raddr;
	logic [CNT_W-1:0]  h_wdata, h_rdata;

	tlue_ram #(.WIDTH(KW), .DEPTH(KEY_SLOTS)) u_keys_a (
		.clk(clk), .we(ka_we), .waddr(ka_waddr), .wdata(ka_wdata),
		.raddr(ka_raddr), .rdata(ka_rdata)
	);

	tlue_ram #(.WIDTH(KW), .DEPTH(KEY_SLOTS)) u_keys_b (
		.clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(kb_wdata),
		.raddr(kb_raddr), .rdata(kb_rdata)
	);

	tlue_ram #(.WIDTH(CNT_W), .DEPTH(HIST_D)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	// Handshake and slot status.
	logic accept, slot_free, out_load;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign out_load      = slot_free && ((state_q == S_SUM) || (state_q == S_FETCH_OUT));

	// Vertex ordering of the incoming triangle: three compare-exchange steps.
	logic [INDEX_BITS-1:0] a0, b0, c0, a1, b1, b2, c2, a3, b3;
	always_comb begin
		a0 = s_axis_tdata[INDEX_BITS-1:0];
		b0 = s_axis_tdata[32 +: INDEX_BITS];
		c0 = s_axis_tdata[64 +: INDEX_BITS];
		a1 = (a0 > b0) ? b0 : a0;
		b1 = (a0 > b0) ? a0 : b0;
		b2 = (b1 > c0) ? c0 : b1;
		c2 = (b1 > c0) ? b1 : c0;
		a3 = (a1 > b2) ? b2 : a1;
		b3 = (a1 > b2) ? a1 : b2;
	end

	// Fill level at which this triangle lands; a finished list starts over.
	logic [CNT_W-1:0] base_total;
	logic             tri_fits;
	assign base_total = list_done_q ? '0 : edge_total_q;
	assign tri_fits   = ({1'b0, base_total} + (CNT_W+1)'(3)) <= (CNT_W+1)'(KEY_SLOTS);

	// Source key read data and digit of the key under work.
	logic [KW-1:0]         src_rdata;
	logic [DIGIT_BITS-1:0] src_digit;
	assign src_rdata = src_sel_q ? kb_rdata : ka_rdata;
	assign src_digit = DIGIT_BITS'(src_rdata >> shift_q);

	logic kidx_last;
	assign kidx_last = ({1'b0, kidx_q} + (CNT_W+1)'(1)) == {1'b0, edge_total_q};

	// Summary count from the number of kept keys.
	logic [PAIR_W-1:0] cap_eff, kept_w, pairs, pairs2;
	always_comb begin
		cap_eff = (cap_q == '0) ? PAIR_W'(1) : PAIR_W'(cap_q);
		kept_w  = PAIR_W'(kept_q);
		pairs   = (count_only_q || kept_w < cap_eff) ? kept_w : cap_eff;
		pairs2  = pairs << 1;
	end

	// Fetch status.
	logic fetch_avail;
	assign fetch_avail = list_done_q && (fetch_ptr_q < unique_q);

	// Memory port steering for each state.
	always_comb begin
		ka_we    = 1'b0;
		kb_we    = 1'b0;
		h_we     = 1'b0;
		ka_waddr = kidx_q[ADDR_W-1:0];
		kb_waddr = kidx_q[ADDR_W-1:0];
		ka_wdata = key_q;
		kb_wdata = key_q;
		ka_raddr = fetch_ptr_q[ADDR_W-1:0];
		kb_raddr = fetch_ptr_q[ADDR_W-1:0];
		h_waddr  = hidx_q;
		h_wdata  = '0;
		h_raddr  = hidx_q;
		unique case (state_q)
			S_IDLE: begin
				ka_we    = accept && (s_axis_tuser == tlue_pkg::OP_ADD) && tri_fits;
				ka_waddr = base_total[ADDR_W-1:0];
				ka_wdata = {a3, b3};
			end
			S_LOAD: begin
				ka_we    = 1'b1;
				ka_waddr = edge_total_q[ADDR_W-1:0];
				ka_wdata = (step_q == 2'd1) ? {vb_q, vc_q} : {va_q, vc_q};
			end
			S_CLR: begin
				h_we = 1'b1;
			end
			S_CNT_RD, S_SCT_RD, S_DD_RD: begin
				ka_raddr = kidx_q[ADDR_W-1:0];
				kb_raddr = kidx_q[ADDR_W-1:0];
			end
			S_CNT_HR, S_SCT_HR: begin
				h_raddr = src_digit;
			end
			S_CNT_WR: begin
				h_we    = 1'b1;
				h_waddr = digit_q;
				h_wdata = h_rdata + CNT_W'(1);
			end
			S_PFX_WR: begin
				h_we    = 1'b1;
				h_wdata = run_q;
			end
			S_SCT_WR: begin
				h_we     = 1'b1;
				h_waddr  = digit_q;
				h_wdata  = h_rdata + CNT_W'(1);
				ka_we    = src_sel_q;
				kb_we    = !src_sel_q;
				ka_waddr = h_rdata[ADDR_W-1:0];
				kb_waddr = h_rdata[ADDR_W-1:0];
			end
			S_DD_RD0: begin
				ka_raddr = '0;
				kb_raddr = '0;
			end
			S_DD_CMP: begin
				ka_we    = !src_sel_q && (src_rdata != prev_q);
				kb_we    = src_sel_q && (src_rdata != prev_q);
				ka_waddr = kept_q[ADDR_W-1:0];
				kb_waddr = kept_q[ADDR_W-1:0];
				ka_wdata = src_rdata;
				kb_wdata = src_rdata;
			end
			default: begin
			end
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			cap_q        <= tlue_pkg::CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlue_pkg::REG_COUNT_ONLY: count_only_q <= cfg_data[0];
				tlue_pkg::REG_CAPACITY:   cap_q <= cfg_data[tlue_pkg::CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: loading, radix passes, dedup, summary and fetch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			list_done_q  <= 1'b0;
			edge_total_q <= '0;
			unique_q     <= '0;
			fetch_ptr_q  <= '0;
			out_valid_q  <= 1'b0;
			src_sel_q    <= 1'b0;
			pass_q       <= '0;
			shift_q      <= '0;
			step_q       <= '0;
			last_q       <= 1'b0;
			hidx_q       <= '0;
			kidx_q       <= '0;
			kept_q       <= '0;
			run_q        <= '0;
			in_order_q   <= 1'b1;
		end else begin
			// The result slot fills on a new result and empties when the beat is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_axis_tuser == tlue_pkg::OP_FETCH) begin
						state_q <= S_FETCH_RD;
					end else if (accept) begin
						if (list_done_q) begin
							list_done_q <= 1'b0;
							unique_q    <= '0;
							fetch_ptr_q <= '0;
						end
						va_q   <= a3;
						vb_q   <= b3;
						vc_q   <= c2;
						last_q <= s_axis_tlast;
						step_q <= 2'd1;
						if (tri_fits) begin
							edge_total_q <= base_total + CNT_W'(1);
							state_q      <= S_LOAD;
						end else begin
							edge_total_q <= base_total;
							state_q      <= s_axis_tlast ? S_START : S_IDLE;
						end
					end
				end
				S_LOAD: begin
					edge_total_q <= edge_total_q + CNT_W'(1);
					step_q       <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						state_q <= last_q ? S_START : S_IDLE;
					end
				end
				S_START: begin
					src_sel_q <= 1'b0;
					pass_q    <= '0;
					shift_q   <= '0;
					hidx_q    <= '0;
					kept_q    <= '0;
					state_q   <= (edge_total_q == '0) ? S_SUM : S_CLR;
				end
				// Histogram clear sweep.
				S_CLR: begin
					hidx_q <= hidx_q + DIGIT_BITS'(1);
					if (&hidx_q) begin
						kidx_q     <= '0;
						in_order_q <= 1'b1;
						state_q    <= S_CNT_RD;
					end
				end
				// Digit count with the in-order check.
				S_CNT_RD: state_q <= S_CNT_HR;
				S_CNT_HR: begin
					digit_q <= src_digit;
					prev_q  <= src_rdata;
					if (kidx_q != '0 && prev_q > src_rdata) begin
						in_order_q <= 1'b0;
					end
					state_q <= S_CNT_WR;
				end
				S_CNT_WR: begin
					kidx_q <= kidx_q + CNT_W'(1);
					if (!kidx_last) begin
						state_q <= S_CNT_RD;
					end else if (in_order_q) begin
						state_q <= S_DD_RD0;
					end else begin
						hidx_q  <= '0;
						run_q   <= '0;
						state_q <= S_PFX_RD;
					end
				end
				// Exclusive prefix sum over the histogram.
				S_PFX_RD: state_q <= S_PFX_WR;
				S_PFX_WR: begin
					run_q  <= run_q + h_rdata;
					hidx_q <= hidx_q + DIGIT_BITS'(1);
					if (&hidx_q) begin
						kidx_q  <= '0;
						state_q <= S_SCT_RD;
					end else begin
						state_q <= S_PFX_RD;
					end
				end
				// Scatter into the other key memory.
				S_SCT_RD: state_q <= S_SCT_HR;
				S_SCT_HR: begin
					digit_q <= src_digit;
					key_q   <= src_rdata;
					state_q <= S_SCT_WR;
				end
				S_SCT_WR: begin
					kidx_q <= kidx_q + CNT_W'(1);
					if (!kidx_last) begin
						state_q <= S_SCT_RD;
					end else begin
						src_sel_q <= !src_sel_q;
						pass_q    <= pass_q + PASS_W'(1);
						shift_q   <= shift_q + SH_W'(DIGIT_BITS);
						hidx_q    <= '0;
						state_q   <= (pass_q == PASS_W'(PASSES - 1)) ? S_DD_RD0 : S_CLR;
					end
				end
				// Duplicate removal in place.
				S_DD_RD0: state_q <= S_DD_FIRST;
				S_DD_FIRST: begin
					prev_q  <= src_rdata;
					kept_q  <= CNT_W'(1);
					kidx_q  <= CNT_W'(1);
					state_q <= (edge_total_q == CNT_W'(1)) ? S_SUM : S_DD_RD;
				end
				S_DD_RD: state_q <= S_DD_CMP;
				S_DD_CMP: begin
					if (src_rdata != prev_q) begin
						prev_q <= src_rdata;
						kept_q <= kept_q + CNT_W'(1);
					end
					kidx_q  <= kidx_q + CNT_W'(1);
					state_q <= kidx_last ? S_SUM : S_DD_RD;
				end
				// Summary result.
				S_SUM: begin
					if (slot_free) begin
						out_kind_q  <= tlue_pkg::KIND_SUMMARY;
						out_vres_q  <= 1'b1;
						out_hi_q    <= '0;
						out_lo_q    <= '0;
						out_final_q <= 1'b0;
						out_count_q <= (pairs2 > PAIR_W'(tlue_pkg::COUNT_MAX)) ?
							tlue_pkg::COUNT_MAX : tlue_pkg::COUNT_W'(pairs2);
						list_done_q <= 1'b1;
						fetch_ptr_q <= '0;
						unique_q    <= count_only_q ? '0 : pairs[CNT_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				// Edge fetch.
				S_FETCH_RD: state_q <= S_FETCH_OUT;
				S_FETCH_OUT: begin
					if (slot_free) begin
						out_kind_q  <= tlue_pkg::KIND_EDGE;
						out_vres_q  <= fetch_avail;
						out_hi_q    <= fetch_avail ?
							tlue_pkg::VERTEX_W'(src_rdata[INDEX_BITS-1:0]) : '0;
						out_lo_q    <= fetch_avail ?
							tlue_pkg::VERTEX_W'(src_rdata[KW-1:INDEX_BITS]) : '0;
						out_final_q <= fetch_avail &&
							(({1'b0, fetch_ptr_q} + (CNT_W+1)'(1)) == {1'b0, unique_q});
						out_count_q <= '0;
						if (fetch_avail) begin
							fetch_ptr_q <= fetch_ptr_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result port.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_final_q;
	assign m_axis_tdata  = {2'b00, out_count_q, out_lo_q, out_hi_q, out_vres_q};

endmodule : triangle_list_to_unique_edges
`default_nettype wire

// File: bench/tb_triangle_list_to_unique_edges.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_list_to_unique_edges: self-checking bench for the edge extractor
// Streams triangle lists and fetch beats into the block. A behavioral model
// predicts the summary count and the sorted unique edges, and every result beat
// is checked in order. Both stream sides idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_triangle_list_to_unique_edges;

	localparam int KEY_SLOTS  = 3 * tlue_pkg::MAX_TRIANGLES_DEF;
	localparam int IDLE_LIMIT = 1000000;

	typedef struct {
		logic                          kind;
		logic                          valid_res;
		logic [tlue_pkg::VERTEX_W-1:0] vertex_high;
		logic [tlue_pkg::VERTEX_W-1:0] vertex_low;
		logic                          final_edge;
		logic [tlue_pkg::COUNT_W-1:0]  index_count;
	} edge_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic                             cfg_index = tlue_pkg::REG_COUNT_ONLY;
	logic [tlue_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// tdata: first_vertex[31:0], second_vertex[63:32], third_vertex[95:64]
	logic [tlue_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// tuser: opcode
	logic                             s_axis_tuser = tlue_pkg::OP_ADD;
	logic                             s_axis_tlast = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// tdata: valid_res[0], vertex_high[32:1], vertex_low[64:33], index_count[77:65]
	logic [tlue_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// tuser: kind
	logic                             m_axis_tuser;
	logic                             m_axis_tlast;

	triangle_list_to_unique_edges dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Model state: stored keys (the map keeps them sorted and unique).
	bit                       stored_keys[bit [63:0]];
	int unsigned              stored_total;
	bit                       list_complete;
	bit [63:0]                kept_edges[$];
	int unsigned              fetchable_pairs;
	int unsigned              fetch_index;
	bit                       model_count_only;
	bit [tlue_pkg::CAP_W-1:0] model_capacity;

	edge_result_t   pending_results[$];
	int             error_count = 0;
	int             idle_cycles = 0;
	int             sender_idle_pct;
	int             receiver_stall_pct;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Close the list: sort, remove duplicates, cap, and predict the summary beat.
	task automatic close_list();
		edge_result_t r;
		int unsigned pairs;
		int unsigned cap;
		list_complete = 1'b1;
		fetch_index = 0;
		fetchable_pairs = 0;
		kept_edges.delete();
		foreach (stored_keys[k])
			kept_edges.push_back(k);
		cap = (model_capacity == 0) ? 1 : model_capacity;
		if (model_count_only)
			pairs = kept_edges.size();
		else begin
			pairs = (kept_edges.size() < cap) ? kept_edges.size() : cap;
			fetchable_pairs = pairs;
		end
		r = '{tlue_pkg::KIND_SUMMARY, 1'b1, '0, '0, 1'b0, '0};
		r.index_count = (2 * pairs > tlue_pkg::COUNT_MAX) ? tlue_pkg::COUNT_MAX :
			tlue_pkg::COUNT_W'(2 * pairs);
		pending_results.push_back(r);
	endtask

	task automatic predict_triangle(input bit [31:0] a, input bit [31:0] b,
			input bit [31:0] c, input bit last);
		bit [31:0] t;
		if (list_complete) begin
			list_complete = 1'b0;
			stored_keys.delete();
			stored_total = 0;
			fetchable_pairs = 0;
			fetch_index = 0;
		end
		if (a > b) begin t = a; a = b; b = t; end
		if (b > c) begin t = b; b = c; c = t; end
		if (a > b) begin t = a; a = b; b = t; end
		if (stored_total + 3 <= KEY_SLOTS) begin
			stored_keys[{a, b}] = 1'b1;
			stored_keys[{b, c}] = 1'b1;
			stored_keys[{a, c}] = 1'b1;
			stored_total += 3;
		end
		if (last)
			close_list();
	endtask

	task automatic predict_fetch();
		edge_result_t r;
		r = '{tlue_pkg::KIND_EDGE, 1'b0, '0, '0, 1'b0, '0};
		if (list_complete && fetch_index < fetchable_pairs) begin
			r.valid_res = 1'b1;
			r.vertex_high = kept_edges[fetch_index][31:0];
			r.vertex_low = kept_edges[fetch_index][63:32];
			r.final_edge = (fetch_index + 1 == fetchable_pairs);
			fetch_index++;
		end
		pending_results.push_back(r);
	endtask

	// Send one beat with random idle gaps ahead of it; predict on acceptance.
	task automatic send_beat(input bit op, input bit [31:0] a, input bit [31:0] b,
			input bit [31:0] c, input bit last);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {c, b, a};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op == tlue_pkg::OP_ADD)
			predict_triangle(a, b, c, last);
		else
			predict_fetch();
	endtask

	task automatic send_triangle(input bit [31:0] a, input bit [31:0] b,
			input bit [31:0] c, input bit last);
		send_beat(tlue_pkg::OP_ADD, a, b, c, last);
	endtask

	task automatic send_fetches(input int n);
		for (int i = 0; i < n; i++)
			send_beat(tlue_pkg::OP_FETCH, $urandom, $urandom, $urandom,
				$urandom_range(0, 1));
	endtask

	// Stop sending and wait until every predicted beat has come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [tlue_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == tlue_pkg::REG_COUNT_ONLY)
			model_count_only = value[0];
		else
			model_capacity = value;
	endtask

	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
			1: begin sender_idle_pct = 53; receiver_stall_pct = 0; end
			2: begin sender_idle_pct = 0; receiver_stall_pct = 53; end
			default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
		endcase
	endtask

	// Extremes, degenerate triangles, fetch before completion, count-only mode,
	// fetch past the end and the capacity floor of one pair.
	task automatic test_directed();
		set_idling(0);
		send_fetches(1);
		drain();
		write_reg(tlue_pkg::REG_CAPACITY, 12'hFFF);
		send_triangle(32'h0, 32'h0, 32'h0, 1'b0);
		send_triangle(32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 1'b0);
		send_triangle(32'h5555_5555, 32'hFFFF_FFFF, 32'h0, 1'b1);
		send_fetches(8);
		drain();
		write_reg(tlue_pkg::REG_COUNT_ONLY, 12'd1);
		send_triangle(32'd1, 32'd2, 32'd3, 1'b0);
		send_triangle(32'd3, 32'd2, 32'd4, 1'b1);
		send_fetches(1);
		drain();
		write_reg(tlue_pkg::REG_COUNT_ONLY, 12'd0);
		write_reg(tlue_pkg::REG_CAPACITY, 12'd0);
		send_triangle(32'd9, 32'd7, 32'd8, 1'b0);
		send_fetches(1);
		send_triangle(32'd7, 32'd7, 32'd9, 1'b1);
		send_fetches(3);
		drain();
	endtask

	// Overfill the key store: triangles past the limit are dropped.
	task automatic test_full_store();
		set_idling(0);
		write_reg(tlue_pkg::REG_CAPACITY, tlue_pkg::CAP_RESET);
		for (int i = 0; i < tlue_pkg::MAX_TRIANGLES_DEF + 6; i++)
			send_triangle($urandom_range(0, 4000), $urandom_range(0, 4000),
				$urandom, i == tlue_pkg::MAX_TRIANGLES_DEF + 5);
		send_fetches(30);
		drain();
	endtask

	// Random lists with random settings, then fetches up to and sometimes past the end of each.
	task automatic test_random_lists();
		int ntri;
		int narrow;
		for (int list = 0; list < 12; list++) begin
			set_idling(list);
			write_reg(tlue_pkg::REG_COUNT_ONLY,
				tlue_pkg::CFG_DATA_W'($urandom_range(0, 4) == 0));
			case ($urandom_range(0, 5))
				0: write_reg(tlue_pkg::REG_CAPACITY, 12'd0);
				1: write_reg(tlue_pkg::REG_CAPACITY, 12'd1);
				2: write_reg(tlue_pkg::REG_CAPACITY, 12'hFFF);
				3: write_reg(tlue_pkg::REG_CAPACITY,
					tlue_pkg::CFG_DATA_W'($urandom_range(2, 30)));
				4: write_reg(tlue_pkg::REG_CAPACITY, tlue_pkg::CFG_DATA_W'($urandom));
				default: write_reg(tlue_pkg::REG_CAPACITY, tlue_pkg::CAP_RESET);
			endcase
			ntri = $urandom_range(1, 20);
			narrow = $urandom_range(0, 2);
			for (int t = 0; t < ntri; t++) begin
				if ($urandom_range(0, 19) == 0)
					send_fetches(1);
				if (list == 5)
					send_triangle(32'd4, 32'd2, 32'd6, t == ntri - 1);
				else if (narrow == 0)
					send_triangle($urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), t == ntri - 1);
				else
					send_triangle($urandom, $urandom, $urandom, t == ntri - 1);
			end
			send_fetches(fetchable_pairs + $urandom_range(0, 3));
			drain();
		end
	endtask

	// Receiver side: random stalls.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	// Check each result beat against the oldest prediction.
	always @(posedge clk) begin
		edge_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected result beat", m_axis_tdata[63:0], 64'h0);
			else begin
				r = pending_results.pop_front();
				if (m_axis_tuser !== r.kind)
					report_mismatch("kind", 64'(m_axis_tuser), 64'(r.kind));
				if (m_axis_tdata[0] !== r.valid_res)
					report_mismatch("valid_res", 64'(m_axis_tdata[0]), 64'(r.valid_res));
				if (m_axis_tdata[32:1] !== r.vertex_high)
					report_mismatch("vertex_high", 64'(m_axis_tdata[32:1]),
						64'(r.vertex_high));
				if (m_axis_tdata[64:33] !== r.vertex_low)
					report_mismatch("vertex_low", 64'(m_axis_tdata[64:33]),
						64'(r.vertex_low));
				if (m_axis_tlast !== r.final_edge)
					report_mismatch("final_edge", 64'(m_axis_tlast), 64'(r.final_edge));
				if (m_axis_tdata[77:65] !== r.index_count)
					report_mismatch("index_count", 64'(m_axis_tdata[77:65]),
						64'(r.index_count));
			end
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		stored_total = 0;
		list_complete = 1'b0;
		fetchable_pairs = 0;
		fetch_index = 0;
		model_count_only = 1'b0;
		model_capacity = tlue_pkg::CAP_RESET;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_store();
		test_random_lists();
		drain();
		repeat (50) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
